>>> sv/lcfp_pkg.sv
`default_nettype none
package lcfp_pkg;

  localparam int CFG_BUFFER_BYTES_DEF = 512;
  localparam int ADDRESS_CHARS_DEF    = 20;

  localparam logic [7:0] SYNC_BYTE0 = 8'h01;
  localparam logic [7:0] SYNC_BYTE1 = 8'h02;
  localparam logic [7:0] SYNC_BYTE2 = 8'h03;

  localparam logic [7:0] CMD_EMERG_OFF = 8'd1;
  localparam logic [7:0] CMD_ON        = 8'd2;
  localparam logic [7:0] CMD_STANDBY   = 8'd3;
  localparam logic [7:0] CMD_ACTIVE    = 8'd4;
  localparam logic [7:0] CMD_CONFIG    = 8'h05;
  localparam logic [7:0] CMD_ADDRESS   = 8'd6;
  localparam logic [7:0] CMD_SEND_REQ  = 8'd7;

  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_EMERG_OFF   = 4'd1;
  localparam logic [3:0] EV_ON          = 4'd2;
  localparam logic [3:0] EV_STANDBY     = 4'd3;
  localparam logic [3:0] EV_ACTIVE      = 4'd4;
  localparam logic [3:0] EV_CFG_START   = 4'd5;
  localparam logic [3:0] EV_CFG_REFUSED = 4'd6;
  localparam logic [3:0] EV_CFG_DONE    = 4'd7;
  localparam logic [3:0] EV_CFG_ERROR   = 4'd8;
  localparam logic [3:0] EV_ADDR_DONE   = 4'd9;

  localparam int HEADER_BYTES  = 4;
  localparam int MIN_FRAME_LEN = 5;
  localparam int CRC_BYTES     = 2;

  typedef struct packed {
    logic [3:0] event_res;
    logic       store_valid;
    logic       store_to_address;
    logic [8:0] store_index;
    logic [7:0] store_data;
    logic [8:0] frame_length;
    logic       send_config_request;
  } result_t;

endpackage
`default_nettype wire

>>> sv/lcfp_out_buf.sv
`default_nettype none
module lcfp_out_buf
  import lcfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire result_t push_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_d_r;
  result_t skid_d_r;
  logic    push;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign out_valid  = main_v_r;
  assign out_data   = main_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      // main slot free or draining this cycle
      main_v_r <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/link_command_frame_parser.sv
`default_nettype none
// channel  | ports                              | role
// ---------+------------------------------------+----------------------------
// in       | in_valid/in_ready, in_func,        | received byte or consume
//          | in_rx_byte                         | request, one per transfer
// out      | out_valid/out_ready, out_event_res | one result per input
//          | out_store_*, out_frame_length, ... | transfer
// one input transfer per cycle while in_ready is high; each result is registered
// the parser state is updated in the cycle of acceptance by one pass of logic
// a two-entry output buffer keeps in_ready high while one result waits
// in_ready drops only when both output entries are full
// synchronous active-low reset returns the parser to idle and empties the buffer
module link_command_frame_parser
  import lcfp_pkg::*;
#(
  parameter int CFG_BUFFER_BYTES = CFG_BUFFER_BYTES_DEF,
  parameter int ADDRESS_CHARS    = ADDRESS_CHARS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_event_res,
  output logic            out_store_valid,
  output logic            out_store_to_address,
  output logic [8:0]      out_store_index,
  output logic [7:0]      out_store_data,
  output logic [8:0]      out_frame_length,
  output logic            out_send_config_request
);

  localparam int IDX_MAX = (CFG_BUFFER_BYTES > ADDRESS_CHARS) ? CFG_BUFFER_BYTES
                                                              : ADDRESS_CHARS;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam logic [IDX_W-1:0] CFG_LIMIT  = IDX_W'(CFG_BUFFER_BYTES);
  localparam logic [IDX_W-1:0] ADDR_LIMIT = IDX_W'(ADDRESS_CHARS);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SYNC1  = 3'd1,
    PH_SYNC2  = 3'd2,
    PH_CMD    = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_LEN_LO = 3'd5,
    PH_BODY   = 3'd6,
    PH_ADDR   = 3'd7
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic             pending_r, pending_nxt;
  logic             connected_r, connected_nxt;

  logic [IDX_W-1:0] idx_inc;
  logic [15:0]      len_full;
  logic [15:0]      rem_dec;
  logic             accept;
  result_t          res;
  result_t          out_res;

  assign idx_inc  = idx_r + IDX_W'(1);
  assign len_full = {rem_r[15:8], in_rx_byte};
  assign rem_dec  = rem_r - 16'd1;

  always_comb begin
    res           = '0;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    pending_nxt   = pending_r;
    connected_nxt = connected_r;
    if (in_func) begin
      pending_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_SYNC1: begin
          phase_nxt = (in_rx_byte == SYNC_BYTE1) ? PH_SYNC2 : PH_IDLE;
        end
        PH_SYNC2: begin
          phase_nxt = (in_rx_byte == SYNC_BYTE2) ? PH_CMD : PH_IDLE;
        end
        PH_CMD: begin
          phase_nxt = PH_IDLE;
          case (in_rx_byte)
            CMD_EMERG_OFF: res.event_res = EV_EMERG_OFF;
            CMD_ON:        res.event_res = EV_ON;
            CMD_STANDBY:   res.event_res = EV_STANDBY;
            CMD_ACTIVE:    res.event_res = EV_ACTIVE;
            CMD_CONFIG: begin
              if (pending_r) begin
                res.event_res = EV_CFG_REFUSED;
              end else begin
                res.event_res = EV_CFG_START;
                idx_nxt       = IDX_W'(HEADER_BYTES);
                phase_nxt     = PH_LEN_HI;
              end
            end
            CMD_ADDRESS: begin
              idx_nxt   = '0;
              phase_nxt = PH_ADDR;
            end
            CMD_SEND_REQ: res.send_config_request = 1'b1;
            default: ;
          endcase
        end
        PH_LEN_HI: begin
          res.store_valid = 1'b1;
          res.store_index = 9'(idx_r);
          res.store_data  = in_rx_byte;
          idx_nxt         = idx_inc;
          rem_nxt         = {in_rx_byte, 8'h00};
          phase_nxt       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          res.store_valid = 1'b1;
          res.store_index = 9'(idx_r);
          res.store_data  = in_rx_byte;
          idx_nxt         = idx_inc;
          if (len_full < 16'(MIN_FRAME_LEN)) begin
            res.event_res = EV_CFG_ERROR;
            rem_nxt       = '0;
            phase_nxt     = PH_IDLE;
          end else begin
            rem_nxt   = len_full - 16'(HEADER_BYTES);
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (idx_r >= CFG_LIMIT) begin
            // overflow: byte dropped, frame aborted
            res.event_res = EV_CFG_ERROR;
            rem_nxt       = '0;
            phase_nxt     = PH_IDLE;
          end else begin
            res.store_valid = 1'b1;
            res.store_index = 9'(idx_r);
            res.store_data  = in_rx_byte;
            idx_nxt         = idx_inc;
            rem_nxt         = rem_dec;
            if (rem_dec == 16'd0) begin
              res.event_res    = EV_CFG_DONE;
              res.frame_length = 9'(idx_inc - IDX_W'(CRC_BYTES));
              pending_nxt      = 1'b1;
              phase_nxt        = PH_IDLE;
            end
          end
        end
        PH_ADDR: begin
          if (idx_r < ADDR_LIMIT) begin
            res.store_valid      = 1'b1;
            res.store_to_address = 1'b1;
            res.store_index      = 9'(idx_r);
            res.store_data       = in_rx_byte;
            idx_nxt              = idx_inc;
          end
          if (idx_nxt >= ADDR_LIMIT) begin
            res.event_res = EV_ADDR_DONE;
            if (!connected_r) begin
              connected_nxt           = 1'b1;
              res.send_config_request = 1'b1;
            end
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = (in_rx_byte == SYNC_BYTE0) ? PH_SYNC1 : PH_IDLE;
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      rem_r       <= '0;
      pending_r   <= 1'b0;
      connected_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
      pending_r   <= pending_nxt;
      connected_r <= connected_nxt;
    end
  end

  lcfp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_res)
  );

  assign out_event_res           = out_res.event_res;
  assign out_store_valid         = out_res.store_valid;
  assign out_store_to_address    = out_res.store_to_address;
  assign out_store_index         = out_res.store_index;
  assign out_store_data          = out_res.store_data;
  assign out_frame_length        = out_res.frame_length;
  assign out_send_config_request = out_res.send_config_request;

endmodule
`default_nettype wire

>>> sv/lcfp_checker.sv
`default_nettype none
module lcfp_checker
  import lcfp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_event_res,
  input wire logic       out_store_valid,
  input wire logic       out_store_to_address,
  input wire logic [8:0] out_store_index,
  input wire logic [7:0] out_store_data,
  input wire logic [8:0] out_frame_length,
  input wire logic       out_send_config_request
);

  // no result may appear in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a result without a store carries zero store fields
  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_store_valid) |->
      (out_store_index == 9'd0 && out_store_data == 8'd0 && !out_store_to_address))
    else $error("store fields set without store");

  // frame length is only reported with the config done event
  a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_length != 9'd0) |-> (out_event_res == EV_CFG_DONE))
    else $error("frame length outside config done");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_event_res) && $stable(out_store_index)
       && $stable(out_store_data) && $stable(out_send_config_request)))
    else $error("stalled result changed");

  // input is never refused while the output side is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !out_valid) |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind link_command_frame_parser lcfp_checker u_lcfp_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_ready                (in_ready),
  .out_valid               (out_valid),
  .out_ready               (out_ready),
  .out_event_res           (out_event_res),
  .out_store_valid         (out_store_valid),
  .out_store_to_address    (out_store_to_address),
  .out_store_index         (out_store_index),
  .out_store_data          (out_store_data),
  .out_frame_length        (out_frame_length),
  .out_send_config_request (out_send_config_request)
);
`default_nettype wire
